// ===== rtl/core/rrds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrds_pkg;

    // Lane count and fixed field widths
    localparam int REASON_COUNT_DEF = 10;
    localparam int MASK_W           = 10;
    localparam int LANE_IDX_W       = 4;
    localparam int DUR_W            = 16;
    localparam int TIME_W           = 32;
    localparam int CNT_W            = 8;

    // Item opcodes
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FRAME = 1'b1
    } opcode_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_FRAME_INTERVAL = 1'b0,
        CFG_LEGACY_LEVEL   = 1'b1
    } cfg_index_t;

    // Per-word control broadcast from the pipeline to every lane
    typedef struct packed {
        logic              frame_en;
        logic              load_en;
        logic              bank;
        logic              raw;
        logic              legacy_on;
        logic [DUR_W-1:0]  legacy_level;
        logic [CNT_W-1:0]  pushes;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] since;
    } lane_ctrl_t;

    // Threshold entry carried by a load word
    typedef struct packed {
        logic [LANE_IDX_W-1:0] reason;
        logic [DUR_W-1:0]      time_limit;
        logic [CNT_W-1:0]      push_limit;
        logic [CNT_W-1:0]      trigger_limit;
        logic [TIME_W-1:0]     window;
    } lane_entry_t;

endpackage : rrds_pkg

`default_nettype wire

// ===== rtl/core/rrds_time.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrds_time (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic [rrds_pkg::DUR_W-1:0]  interval,
    input  wire logic [rrds_pkg::TIME_W-1:0] frame_number,
    input  wire logic [rrds_pkg::TIME_W-1:0] screen_on_frame,
    output logic      [rrds_pkg::TIME_W-1:0] now,
    output logic      [rrds_pkg::TIME_W-1:0] since
);
    import rrds_pkg::*;

    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] since_reg;
    logic [TIME_W-1:0] now_next;
    logic [TIME_W-1:0] since_next;
    logic [TIME_W-1:0] interval_ext;
    logic [TIME_W-1:0] frame_delta;

    // Scale frame numbers to milliseconds, modulo 2^32
    always_comb
    begin
        interval_ext = TIME_W'(interval);
        frame_delta  = frame_number - screen_on_frame;
        now_next     = frame_number * interval_ext;
        since_next   = frame_delta * interval_ext;
    end

    // Hold products for the lane stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            now_reg   <= now_next;
            since_reg <= since_next;
        end
    end

    assign now   = now_reg;
    assign since = since_reg;

endmodule : rrds_time

`default_nettype wire

// ===== rtl/core/rrds_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrds_lane #(
    parameter int LANE = 0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rrds_pkg::lane_ctrl_t    ctrl,
    input  wire rrds_pkg::lane_entry_t   entry,
    input  wire logic                    asserted,
    output logic                         trig,
    output logic                         active
);
    import rrds_pkg::*;

    localparam logic [DUR_W-1:0] DUR_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Per-bank lane state and thresholds
    logic [DUR_W-1:0]  duration_reg   [2];
    logic [TIME_W-1:0] last_time_reg  [2];
    logic [CNT_W-1:0]  push_count_reg [2];
    logic [DUR_W-1:0]  time_limit_reg [2];
    logic [CNT_W-1:0]  push_limit_reg [2];
    logic [CNT_W-1:0]  trig_limit_reg [2];
    logic [TIME_W-1:0] window_reg     [2];

    logic [DUR_W-1:0]  duration_next;
    logic [CNT_W-1:0]  push_count_next;
    logic [DUR_W-1:0]  old_dur;
    logic [TIME_W-1:0] last;
    logic [CNT_W-1:0]  pc;
    logic [DUR_W-1:0]  thr;
    logic [TIME_W-1:0] diff;
    logic [DUR_W-1:0]  elapsed;
    logic [DUR_W:0]    sum;
    logic              allowed;
    logic              crossed;
    logic              load_hit;

    assign load_hit = ctrl.load_en && (entry.reason == LANE_IDX_W'(LANE));

    // Compute the frame update for the selected bank
    always_comb
    begin
        old_dur = duration_reg[ctrl.bank];
        last    = last_time_reg[ctrl.bank];
        pc      = push_count_reg[ctrl.bank];
        thr     = ctrl.legacy_on ? ctrl.legacy_level : time_limit_reg[ctrl.bank];

        // Elapsed time, forced to one and capped at the counter range
        diff = ctrl.now - last;
        if ((diff == '0) || (last == '0))
            elapsed = DUR_W'(1);
        else if (diff > TIME_W'(DUR_MAX))
            elapsed = DUR_MAX;
        else
            elapsed = diff[DUR_W-1:0];

        // Gate by screen window and quotas
        allowed = ctrl.raw || (ctrl.since <= window_reg[ctrl.bank]);
        if (!ctrl.raw && !ctrl.legacy_on)
        begin
            if ((trig_limit_reg[ctrl.bank] != '0) && (pc >= trig_limit_reg[ctrl.bank]))
                allowed = 1'b0;
            if ((push_limit_reg[ctrl.bank] != '0) && (ctrl.pushes >= push_limit_reg[ctrl.bank]))
                allowed = 1'b0;
        end

        sum             = {1'b0, old_dur} + {1'b0, elapsed};
        duration_next   = old_dur;
        push_count_next = pc;
        trig            = 1'b0;

        // Accumulate or decay
        if (asserted && allowed)
        begin
            duration_next = sum[DUR_W] ? DUR_MAX : sum[DUR_W-1:0];
            if ((old_dur < thr) && (duration_next >= thr))
            begin
                if (pc != CNT_MAX)
                    push_count_next = pc + CNT_W'(1);
                trig = 1'b1;
            end
        end
        else if (old_dur != '0)
        begin
            duration_next = (old_dur > elapsed) ? (old_dur - elapsed) : '0;
            if ((duration_next == '0) && (pc != '0))
                push_count_next = pc - CNT_W'(1);
        end

        crossed = (old_dur < thr) && (duration_next >= thr);
        if (ctrl.legacy_on && crossed)
            trig = 1'b1;
        active = (duration_next >= thr);
    end

    // Commit frame updates and threshold loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 2; b++)
            begin
                duration_reg[b]   <= '0;
                last_time_reg[b]  <= '0;
                push_count_reg[b] <= '0;
                time_limit_reg[b] <= '0;
                push_limit_reg[b] <= '0;
                trig_limit_reg[b] <= '0;
                window_reg[b]     <= '0;
            end
        end
        else
        begin
            if (ctrl.frame_en)
            begin
                duration_reg[ctrl.bank]   <= duration_next;
                last_time_reg[ctrl.bank]  <= ctrl.now;
                push_count_reg[ctrl.bank] <= push_count_next;
            end
            if (load_hit)
            begin
                time_limit_reg[ctrl.bank] <= entry.time_limit;
                push_limit_reg[ctrl.bank] <= entry.push_limit;
                trig_limit_reg[ctrl.bank] <= entry.trigger_limit;
                window_reg[ctrl.bank]     <= entry.window;
            end
        end
    end

endmodule : rrds_lane

`default_nettype wire

// ===== rtl/core/reset_reason_duration_statistics.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Reset-reason duration statistics over two banks (main and side) of reason
// lanes. Each input word is either a threshold load for one lane of one bank
// or a frame that updates every lane of the chosen bank at once; every word
// yields exactly one result word (all zero for loads). Throughput is one word
// per clock while out_stall is low; the two 32x16 multipliers that turn frame
// numbers into milliseconds work on a word while it is offered and are
// registered as it is accepted, then the lane stage runs all lanes side by
// side and merges their trigger flags and threshold mask into the output
// register. Lane state is read and written in the same lane cycle, so
// consecutive frames on the same bank need no forwarding. The config port is
// always ready; write it only while no word is in flight. Lane state,
// configuration and valid flags reset asynchronously; there is no clearing pass.
module reset_reason_duration_statistics #(
    parameter int REASON_COUNT = rrds_pkg::REASON_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [rrds_pkg::DUR_W-1:0]     cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          opcode,
    input  wire logic [rrds_pkg::MASK_W-1:0]    reason_bits,
    input  wire logic                          raw_checked,
    input  wire logic                          bank_select,
    input  wire logic [rrds_pkg::TIME_W-1:0]    frame_number,
    input  wire logic [rrds_pkg::TIME_W-1:0]    screen_on_frame,
    input  wire logic [rrds_pkg::CNT_W-1:0]     pushes_so_far,
    input  wire logic [rrds_pkg::LANE_IDX_W-1:0] entry_reason,
    input  wire logic [rrds_pkg::DUR_W-1:0]     entry_time_limit,
    input  wire logic [rrds_pkg::CNT_W-1:0]     entry_push_limit,
    input  wire logic [rrds_pkg::CNT_W-1:0]     entry_trigger_limit,
    input  wire logic [rrds_pkg::TIME_W-1:0]    entry_screen_window,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               reset_triggered,
    output logic      [rrds_pkg::MASK_W-1:0]    active_reasons
);
    import rrds_pkg::*;

    // Configuration registers
    logic [DUR_W-1:0] frame_interval_reg;
    logic [DUR_W-1:0] legacy_level_reg;
    logic [DUR_W-1:0] interval_eff;

    // Lane-stage registers
    logic              s1_valid_reg;
    opcode_t           s1_opcode_reg;
    logic [MASK_W-1:0] s1_bits_reg;
    logic              s1_raw_reg;
    logic              s1_bank_reg;
    logic [CNT_W-1:0]  s1_pushes_reg;
    lane_entry_t       s1_entry_reg;
    logic [TIME_W-1:0] s1_now;
    logic [TIME_W-1:0] s1_since;

    // Output registers
    logic              out_valid_reg;
    logic              trig_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              trig_next;
    logic [MASK_W-1:0] mask_next;

    logic              advance;
    logic              s1_load;
    logic              fire;
    lane_ctrl_t        ctrl;
    logic [REASON_COUNT-1:0] lane_trig;
    logic [REASON_COUNT-1:0] lane_active;
    logic [REASON_COUNT-1:0] lane_asserted;

    // Handshake: output moves when empty or taken, lane stage refills behind it
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign s1_load   = in_valid && !in_stall;
    assign fire      = s1_valid_reg && advance;
    assign cfg_ready = 1'b1;

    assign interval_eff = (frame_interval_reg == '0) ? DUR_W'(1) : frame_interval_reg;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_interval_reg <= DUR_W'(1);
            legacy_level_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_INTERVAL: frame_interval_reg <= cfg_data;
                CFG_LEGACY_LEVEL:   legacy_level_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Scale frame numbers into the lane stage
    rrds_time u_time (
        .clk             (clk),
        .load            (s1_load),
        .interval        (interval_eff),
        .frame_number    (frame_number),
        .screen_on_frame (screen_on_frame),
        .now             (s1_now),
        .since           (s1_since)
    );

    // Advance the lane stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_opcode_reg              <= opcode_t'(opcode);
            s1_bits_reg                <= reason_bits;
            s1_raw_reg                 <= raw_checked;
            s1_bank_reg                <= bank_select;
            s1_pushes_reg              <= pushes_so_far;
            s1_entry_reg.reason        <= entry_reason;
            s1_entry_reg.time_limit    <= entry_time_limit;
            s1_entry_reg.push_limit    <= entry_push_limit;
            s1_entry_reg.trigger_limit <= entry_trigger_limit;
            s1_entry_reg.window        <= entry_screen_window;
        end
    end

    // Broadcast control to the lanes
    always_comb
    begin
        ctrl.frame_en     = fire && (s1_opcode_reg == OP_FRAME);
        ctrl.load_en      = fire && (s1_opcode_reg == OP_LOAD);
        ctrl.bank         = s1_bank_reg;
        ctrl.raw          = s1_raw_reg;
        ctrl.legacy_on    = (legacy_level_reg != '0);
        ctrl.legacy_level = legacy_level_reg;
        ctrl.pushes       = s1_pushes_reg;
        ctrl.now          = s1_now;
        ctrl.since        = s1_since;
    end

    // Reason lanes
    for (genvar i = 0; i < REASON_COUNT; i++)
    begin : g_lane
        if (i < MASK_W)
        begin : g_bit
            assign lane_asserted[i] = s1_bits_reg[i];
        end
        else
        begin : g_none
            assign lane_asserted[i] = 1'b0;
        end

        rrds_lane #(
            .LANE (i)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .entry    (s1_entry_reg),
            .asserted (lane_asserted[i]),
            .trig     (lane_trig[i]),
            .active   (lane_active[i])
        );
    end

    // Merge lane results
    for (genvar j = 0; j < MASK_W; j++)
    begin : g_mask
        if (j < REASON_COUNT)
        begin : g_on
            assign mask_next[j] = (s1_opcode_reg == OP_FRAME) && lane_active[j];
        end
        else
        begin : g_off
            assign mask_next[j] = 1'b0;
        end
    end

    assign trig_next = (s1_opcode_reg == OP_FRAME) && (|lane_trig);

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            trig_reg <= trig_next;
            mask_reg <= mask_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign reset_triggered = trig_reg;
    assign active_reasons  = mask_reg;

endmodule : reset_reason_duration_statistics

`default_nettype wire

// ===== verif/tb_reset_reason_duration_statistics.sv =====
`timescale 1ns / 1ps

module tb_reset_reason_duration_statistics;
    import rrds_pkg::*;

    localparam int LANES = REASON_COUNT_DEF;

    // One input word, one field per port
    typedef struct packed {
        opcode_t               opcode;
        logic [MASK_W-1:0]     reason_bits;
        logic                  raw_checked;
        logic                  bank_select;
        logic [TIME_W-1:0]     frame_number;
        logic [TIME_W-1:0]     screen_on_frame;
        logic [CNT_W-1:0]      pushes_so_far;
        logic [LANE_IDX_W-1:0] entry_reason;
        logic [DUR_W-1:0]      entry_time_limit;
        logic [CNT_W-1:0]      entry_push_limit;
        logic [CNT_W-1:0]      entry_trigger_limit;
        logic [TIME_W-1:0]     entry_screen_window;
    } stat_word_t;

    typedef struct packed {
        logic              triggered;
        logic [MASK_W-1:0] active;
    } stat_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = 1'b0;
    logic [DUR_W-1:0] cfg_data = '0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    stat_word_t drive_word = '0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              reset_triggered;
    logic [MASK_W-1:0] active_reasons;

    // Words waiting for the driver, and results the block still owes
    stat_word_t   pending_words[$];
    stat_result_t owed_results[$];
    stat_result_t got_result;
    stat_result_t want_result;
    int           mismatch_count = 0;
    logic         quiet_mode = 1'b0;

    // Predicted register and lane state
    logic [DUR_W-1:0]  interval_cfg = 16'd1;
    logic [DUR_W-1:0]  legacy_cfg = 16'd0;
    logic [DUR_W-1:0]  lane_dur[2][LANES];
    logic [TIME_W-1:0] lane_stamp[2][LANES];
    logic [CNT_W-1:0]  lane_pushes[2][LANES];
    logic [DUR_W-1:0]  time_lim[2][LANES];
    logic [CNT_W-1:0]  push_quota[2][LANES];
    logic [CNT_W-1:0]  trig_quota[2][LANES];
    logic [TIME_W-1:0] screen_win[2][LANES];

    // Stimulus bookkeeping
    logic [TIME_W-1:0] bank_frame[2];
    logic [MASK_W-1:0] hot_mask;

    reset_reason_duration_statistics i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode              (drive_word.opcode),
        .reason_bits         (drive_word.reason_bits),
        .raw_checked         (drive_word.raw_checked),
        .bank_select         (drive_word.bank_select),
        .frame_number        (drive_word.frame_number),
        .screen_on_frame     (drive_word.screen_on_frame),
        .pushes_so_far       (drive_word.pushes_so_far),
        .entry_reason        (drive_word.entry_reason),
        .entry_time_limit    (drive_word.entry_time_limit),
        .entry_push_limit    (drive_word.entry_push_limit),
        .entry_trigger_limit (drive_word.entry_trigger_limit),
        .entry_screen_window (drive_word.entry_screen_window),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .reset_triggered     (reset_triggered),
        .active_reasons      (active_reasons)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        foreach (lane_dur[b, i])
        begin
            lane_dur[b][i] = '0;
            lane_stamp[b][i] = '0;
            lane_pushes[b][i] = '0;
            time_lim[b][i] = '0;
            push_quota[b][i] = '0;
            trig_quota[b][i] = '0;
            screen_win[b][i] = '0;
        end
    end

    // Apply one accepted word to the predicted state and return its result
    function automatic stat_result_t update_statistics(input stat_word_t w);
        stat_result_t      r;
        logic [TIME_W-1:0] ivl;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] since_ms;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] last;
        logic [DUR_W:0]    sum;
        logic [DUR_W-1:0]  thr;
        logic [DUR_W-1:0]  old;
        logic [DUR_W-1:0]  cur;
        logic [CNT_W-1:0]  pc;
        logic              legacy;
        logic              allowed;
        int                b;
        int                i;
        r = '0;
        b = w.bank_select;
        if (w.opcode == OP_LOAD)
        begin
            if (w.entry_reason < LANES)
            begin
                time_lim[b][w.entry_reason] = w.entry_time_limit;
                push_quota[b][w.entry_reason] = w.entry_push_limit;
                trig_quota[b][w.entry_reason] = w.entry_trigger_limit;
                screen_win[b][w.entry_reason] = w.entry_screen_window;
            end
            return r;
        end
        legacy = (legacy_cfg != 0);
        ivl = (interval_cfg == 0) ? 32'd1 : {16'd0, interval_cfg};
        now_ms = w.frame_number * ivl;
        since_ms = (w.frame_number - w.screen_on_frame) * ivl;
        for (i = 0; i < LANES; i++)
        begin
            thr = legacy ? legacy_cfg : time_lim[b][i];
            old = lane_dur[b][i];
            cur = old;
            last = lane_stamp[b][i];
            elapsed = now_ms - last;
            if (elapsed == 0 || last == 0)
                elapsed = 32'd1;
            if (elapsed > 32'hFFFF)
                elapsed = 32'hFFFF;
            lane_stamp[b][i] = now_ms;
            allowed = w.raw_checked || (since_ms <= screen_win[b][i]);
            pc = lane_pushes[b][i];
            // Quotas only gate when neither raw check nor legacy level applies
            if (!w.raw_checked && !legacy)
            begin
                if (trig_quota[b][i] != 0 && pc >= trig_quota[b][i])
                    allowed = 1'b0;
                if (push_quota[b][i] != 0 && w.pushes_so_far >= push_quota[b][i])
                    allowed = 1'b0;
            end
            if (w.reason_bits[i] && allowed)
            begin
                sum = {1'b0, old} + {1'b0, elapsed[DUR_W-1:0]};
                cur = sum[DUR_W] ? 16'hFFFF : sum[DUR_W-1:0];
                if (old < thr && cur >= thr)
                begin
                    if (pc != 8'hFF)
                        pc = pc + 8'd1;
                    r.triggered = 1'b1;
                end
            end
            else if (cur != 0)
            begin
                // Decay, and give back one push when the counter empties
                cur = (cur > elapsed[DUR_W-1:0]) ? cur - elapsed[DUR_W-1:0] : '0;
                if (cur == 0 && pc != 0)
                    pc = pc - 8'd1;
            end
            if (legacy && old < thr && cur >= thr)
                r.triggered = 1'b1;
            lane_dur[b][i] = cur;
            lane_pushes[b][i] = pc;
            if (cur >= thr)
                r.active[i] = 1'b1;
        end
        return r;
    endfunction

    function automatic stat_word_t scrambled_word();
        stat_word_t w;
        w.opcode = opcode_t'($urandom_range(1));
        w.reason_bits = MASK_W'($urandom);
        w.raw_checked = 1'($urandom);
        w.bank_select = 1'($urandom);
        w.frame_number = $urandom;
        w.screen_on_frame = $urandom;
        w.pushes_so_far = CNT_W'($urandom);
        w.entry_reason = LANE_IDX_W'($urandom);
        w.entry_time_limit = DUR_W'($urandom);
        w.entry_push_limit = CNT_W'($urandom);
        w.entry_trigger_limit = CNT_W'($urandom);
        w.entry_screen_window = $urandom;
        return w;
    endfunction

    task automatic push_frame(input logic [MASK_W-1:0] bits, input logic raw,
                              input logic bank, input logic [TIME_W-1:0] frame,
                              input logic [TIME_W-1:0] screen,
                              input logic [CNT_W-1:0] pushes);
        stat_word_t w;
        w = scrambled_word();
        w.opcode = OP_FRAME;
        w.reason_bits = bits;
        w.raw_checked = raw;
        w.bank_select = bank;
        w.frame_number = frame;
        w.screen_on_frame = screen;
        w.pushes_so_far = pushes;
        pending_words.push_back(w);
    endtask

    task automatic push_load(input logic bank, input logic [LANE_IDX_W-1:0] lane,
                             input logic [DUR_W-1:0] tl, input logic [CNT_W-1:0] pl,
                             input logic [CNT_W-1:0] tq, input logic [TIME_W-1:0] win);
        stat_word_t w;
        w = scrambled_word();
        w.opcode = OP_LOAD;
        w.bank_select = bank;
        w.entry_reason = lane;
        w.entry_time_limit = tl;
        w.entry_push_limit = pl;
        w.entry_trigger_limit = tq;
        w.entry_screen_window = win;
        pending_words.push_back(w);
    endtask

    // Queue random words: mostly slowly advancing frames, loads now and then
    task automatic queue_random(input int count);
        stat_word_t        w;
        logic [TIME_W-1:0] unit;
        int                k;
        int                b;
        int                pick;
        @(negedge clk);
        unit = (interval_cfg == 0) ? 32'd2 : {15'd0, interval_cfg, 1'b0};
        if (unit > 4000)
            unit = 4000;
        for (k = 0; k < count; k++)
        begin
            w = scrambled_word();
            if (k < 12 || $urandom_range(7) == 0)
            begin
                w.opcode = OP_LOAD;
                w.entry_reason = ($urandom_range(7) == 0) ? LANE_IDX_W'($urandom_range(10, 15))
                                                           : LANE_IDX_W'($urandom_range(0, 9));
                pick = $urandom_range(9);
                if (pick == 0)
                    w.entry_time_limit = '0;
                else if (pick == 1)
                    w.entry_time_limit = 16'hFFFF;
                else
                    w.entry_time_limit = DUR_W'(unit * $urandom_range(1, 10));
                w.entry_push_limit = ($urandom_range(2) == 0) ? 8'd0 :
                    ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 4));
                w.entry_trigger_limit = ($urandom_range(2) == 0) ? 8'd0 :
                    ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 4));
                pick = $urandom_range(9);
                if (pick == 0)
                    w.entry_screen_window = '0;
                else if (pick < 3)
                    w.entry_screen_window = unit * $urandom_range(0, 40);
            end
            else
            begin
                w.opcode = OP_FRAME;
                b = $urandom_range(1);
                pick = $urandom_range(99);
                if (pick < 80)
                    bank_frame[b] = bank_frame[b] + $urandom_range(1, 3);
                else if (pick < 90)
                    bank_frame[b] = $urandom;
                else if (pick < 95)
                    bank_frame[b] = 32'hFFFF_FFFF - $urandom_range(3);
                if ($urandom_range(19) == 0)
                    hot_mask = MASK_W'($urandom);
                w.bank_select = 1'(b);
                w.frame_number = bank_frame[b];
                w.reason_bits = ($urandom_range(4) == 0) ? MASK_W'($urandom)
                              : hot_mask ^ MASK_W'($urandom & $urandom & $urandom);
                w.raw_checked = ($urandom_range(3) == 0);
                if ($urandom_range(3) != 0)
                    w.screen_on_frame = bank_frame[b] - $urandom_range(50);
                if ($urandom_range(9) < 7)
                    w.pushes_so_far = CNT_W'($urandom_range(4));
            end
            pending_words.push_back(w);
        end
    endtask

    // Hold until the driver is empty and every owed result has arrived
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [DUR_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_INTERVAL: interval_cfg = data;
            CFG_LEGACY_LEVEL:   legacy_cfg = data;
        endcase
    endtask

    // Driver: predict each accepted word, then present the next one
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                owed_results.push_back(update_statistics(drive_word));
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && (quiet_mode || $urandom_range(99) >= 6))
                begin
                    drive_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest owed one
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_result.triggered = reset_triggered;
                got_result.active = active_reasons;
                if (owed_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got trig %0b mask %h",
                             $time, got_result.triggered, got_result.active);
                end
                else
                begin
                    want_result = owed_results.pop_front();
                    if (got_result.triggered !== want_result.triggered)
                    begin
                        mismatch_count++;
                        $display("%0t: reset_triggered mismatch, expected %0b, got %0b",
                                 $time, want_result.triggered, got_result.triggered);
                    end
                    if (got_result.active !== want_result.active)
                    begin
                        mismatch_count++;
                        $display("%0t: active_reasons mismatch, expected %h, got %h",
                                 $time, want_result.active, got_result.active);
                    end
                end
            end
            out_stall <= !quiet_mode && ($urandom_range(99) < 6);
        end
    end

    initial
    begin
        bank_frame[0] = 32'd10;
        bank_frame[1] = 32'd10;
        hot_mask = MASK_W'($urandom);
        while (!rst_n)
            @(posedge clk);
        @(negedge clk);

        // Directed: empty tables, crossings, quotas, window, wrap and ignored loads
        push_frame(10'h3FF, 1'b0, 1'b0, 32'd1, 32'd1, 8'd0);
        push_load(1'b0, 4'd0, 16'd3, 8'd0, 8'd0, 32'hFFFF_FFFF);
        push_load(1'b0, 4'd1, 16'd2, 8'd2, 8'd1, 32'd10);
        push_load(1'b1, 4'd9, 16'hFFFF, 8'hFF, 8'hFF, 32'd0);
        push_load(1'b1, 4'd0, 16'd0, 8'd0, 8'd0, 32'd0);
        push_load(1'b0, 4'd15, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        push_load(1'b1, 4'd10, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        push_frame(10'h003, 1'b0, 1'b0, 32'd2, 32'd0, 8'd0);
        push_frame(10'h003, 1'b0, 1'b0, 32'd4, 32'd0, 8'd0);
        push_frame(10'h003, 1'b1, 1'b0, 32'd4, 32'd0, 8'd0);
        push_frame(10'h002, 1'b0, 1'b0, 32'd30, 32'd0, 8'd0);
        push_frame(10'h000, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        push_frame(10'h3FF, 1'b0, 1'b0, 32'd0, 32'd0, 8'd0);
        push_frame(10'h3FF, 1'b0, 1'b0, 32'd1, 32'd0, 8'd1);
        push_frame(10'h3FF, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF);
        push_frame(10'h3FF, 1'b1, 1'b1, 32'h8001_86A0, 32'h8001_86A0, 8'hFF);
        push_frame(10'h000, 1'b0, 1'b1, 32'h8001_86A1, 32'h0, 8'h55);
        wait_idle();

        // Random phases, one setting each, with a drain mid-way in the first
        write_reg(CFG_FRAME_INTERVAL, 16'd16);
        queue_random(100);
        wait_idle();
        queue_random(100);
        wait_idle();

        write_reg(CFG_FRAME_INTERVAL, 16'd0);
        queue_random(100);
        wait_idle();

        write_reg(CFG_FRAME_INTERVAL, 16'hFFFF);
        write_reg(CFG_LEGACY_LEVEL, 16'hFFFF);
        queue_random(80);
        wait_idle();

        write_reg(CFG_FRAME_INTERVAL, 16'd5);
        write_reg(CFG_LEGACY_LEVEL, 16'd40);
        queue_random(120);
        wait_idle();

        // Run back to back with no idling on either side
        quiet_mode = 1'b1;
        write_reg(CFG_FRAME_INTERVAL, 16'd1);
        write_reg(CFG_LEGACY_LEVEL, 16'd0);
        queue_random(100);
        wait_idle();
        quiet_mode = 1'b0;

        write_reg(CFG_FRAME_INTERVAL, 16'd1000);
        queue_random(100);
        wait_idle();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rrds_pkg.sv
rtl/core/rrds_time.sv
rtl/core/rrds_lane.sv
rtl/core/reset_reason_duration_statistics.sv
verif/tb_reset_reason_duration_statistics.sv
